// ----- hdl/lcc_pkg.sv -----
package lcc_pkg;

    localparam int IN_W       = 54;
    localparam int KIND_W     = 2;
    localparam int CNT_W      = 5;
    localparam int NDIG       = 17;            // 54-bit value holds at most 17 digits
    localparam int BCD_W      = 4 * NDIG;
    localparam int DD_STEPS   = 6;             // shift-add steps per stage
    localparam int DD_STAGES  = IN_W / DD_STEPS;
    localparam int GRP_SZ     = 6;
    localparam int NGRP       = (NDIG + GRP_SZ - 1) / GRP_SZ;
    localparam int GRP_W      = 6;             // 6 digits * 9 fits 6 bits
    localparam int SUM_W      = 8;             // 17 digits * 9 fits 8 bits
    localparam int MAX_DIGITS = 16;

    localparam logic [KIND_W-1:0] KIND_INVALID  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREFIX3X = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PREFIX5X = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PREFIX4  = 2'd3;

    // doubled digit with its two digits added
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [3:0] r;
        unique case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // one double-dabble step: correct digits >= 5, then shift left
    function automatic logic [BCD_W+IN_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                      input logic [IN_W-1:0]  bin);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < NDIG; k++) begin
            if (adj[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj, bin} << 1;
    endfunction

    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * 10 < (1 << SUM_W); k++) begin
            hit = hit | (s == SUM_W'(10 * k));
        end
        return hit;
    endfunction

endpackage

// ----- hdl/lcc_if.sv -----
interface lcc_in_if;
    import lcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [IN_W-1:0]   card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

interface lcc_out_if;
    import lcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] card_kind;
    logic              luhn_ok;
    logic [CNT_W-1:0]  digit_count;

    modport source (output valid, output card_kind, output luhn_ok, output digit_count,
                    input ready);
    modport sink   (input valid, input card_kind, input luhn_ok, input digit_count,
                    output ready);
endinterface

// ----- hdl/luhn_card_number_classifier.sv -----
// Throughput: one item per cycle unless result.ready stalls the output; the
// binary-to-decimal conversion runs as a 9-stage pipeline of 6 shift-add steps
// each, then 2 stages of digit sum and classification. Per-stage valid bits
// let a stall fill bubbles upstream.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no result shows.
module luhn_card_number_classifier
    import lcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lcc_in_if.sink    card,
    lcc_out_if.source result
);

    localparam int NST = DD_STAGES + 2;
    localparam int S1  = DD_STAGES;
    localparam int S2  = DD_STAGES + 1;

    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   rdy;

    logic [BCD_W-1:0] dd_bcd_reg [DD_STAGES];
    logic [IN_W-1:0]  dd_bin_reg [DD_STAGES];

    logic [GRP_W-1:0]  s1_grp_reg [NGRP];
    logic [GRP_W-1:0]  s1_grp_next [NGRP];
    logic [CNT_W-1:0]  s1_cnt_reg, s1_cnt_next;
    logic [KIND_W-1:0] s1_cand_reg, s1_cand_next;

    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic              out_ok_reg, out_ok_next;
    logic [CNT_W-1:0]  out_cnt_reg;

    // a stage takes new data when it is empty or its content moves on
    always_comb begin
        rdy[NST-1] = !vld_reg[NST-1] || result.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign card.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (rdy[0]) begin
                vld_reg[0] <= card.valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // binary to decimal conversion pipeline
    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        logic [BCD_W+IN_W-1:0] acc;
        logic                  load;

        if (g == 0) begin : g_first
            always_comb begin
                acc  = {{BCD_W{1'b0}}, card.card_number};
                load = card.valid && rdy[0];
                for (int s = 0; s < DD_STEPS; s++) begin
                    acc = dd_step(acc[BCD_W+IN_W-1 -: BCD_W], acc[IN_W-1:0]);
                end
            end
        end
        else begin : g_rest
            always_comb begin
                acc  = {dd_bcd_reg[g-1], dd_bin_reg[g-1]};
                load = vld_reg[g-1] && rdy[g];
                for (int s = 0; s < DD_STEPS; s++) begin
                    acc = dd_step(acc[BCD_W+IN_W-1 -: BCD_W], acc[IN_W-1:0]);
                end
            end
        end

        always_ff @(posedge clk) begin
            if (load) begin
                dd_bcd_reg[g] <= acc[BCD_W+IN_W-1 -: BCD_W];
                dd_bin_reg[g] <= acc[IN_W-1:0];
            end
        end
    end

    // digit stage: partial Luhn sums, digit count, issuer candidate
    always_comb begin
        logic [BCD_W-1:0] d;
        logic [3:0]       c;
        d = dd_bcd_reg[DD_STAGES-1];
        for (int gi = 0; gi < NGRP; gi++) begin
            s1_grp_next[gi] = '0;
            for (int k = 0; k < GRP_SZ; k++) begin
                if (gi * GRP_SZ + k < NDIG) begin
                    c = ((gi * GRP_SZ + k) % 2 == 1) ? luhn_dbl(d[4*(gi*GRP_SZ+k) +: 4])
                                                     : d[4*(gi*GRP_SZ+k) +: 4];
                    s1_grp_next[gi] = s1_grp_next[gi] + GRP_W'(c);
                end
            end
        end

        s1_cnt_next = '0;
        for (int j = 0; j < NDIG; j++) begin
            if (d[4*j +: 4] != 4'd0) begin
                s1_cnt_next = CNT_W'(j + 1);
            end
        end

        // lengths other than 13, 15 and 16 stay invalid
        s1_cand_next = KIND_INVALID;
        if (s1_cnt_next <= CNT_W'(MAX_DIGITS)) begin
            if (s1_cnt_next == CNT_W'(16)) begin
                if (d[4*15 +: 4] == 4'd5 && d[4*14 +: 4] >= 4'd1 &&
                    d[4*14 +: 4] <= 4'd5) begin
                    s1_cand_next = KIND_PREFIX5X;
                end
                else if (d[4*15 +: 4] == 4'd4) begin
                    s1_cand_next = KIND_PREFIX4;
                end
            end
            else if (s1_cnt_next == CNT_W'(15)) begin
                if (d[4*14 +: 4] == 4'd3 &&
                    (d[4*13 +: 4] == 4'd4 || d[4*13 +: 4] == 4'd7)) begin
                    s1_cand_next = KIND_PREFIX3X;
                end
            end
            else if (s1_cnt_next == CNT_W'(13)) begin
                if (d[4*12 +: 4] == 4'd4) begin
                    s1_cand_next = KIND_PREFIX4;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (vld_reg[S1-1] && rdy[S1]) begin
            for (int gi = 0; gi < NGRP; gi++) begin
                s1_grp_reg[gi] <= s1_grp_next[gi];
            end
            s1_cnt_reg  <= s1_cnt_next;
            s1_cand_reg <= s1_cand_next;
        end
    end

    // final sum and check, output register
    always_comb begin
        logic [SUM_W-1:0] total;
        total = '0;
        for (int gi = 0; gi < NGRP; gi++) begin
            total = total + SUM_W'(s1_grp_reg[gi]);
        end
        out_ok_next   = is_mult10(total);
        out_kind_next = out_ok_next ? s1_cand_reg : KIND_INVALID;
    end

    always_ff @(posedge clk) begin
        if (vld_reg[S2-1] && rdy[S2]) begin
            out_kind_reg <= out_kind_next;
            out_ok_reg   <= out_ok_next;
            out_cnt_reg  <= s1_cnt_reg;
        end
    end

    assign result.valid       = vld_reg[S2];
    assign result.card_kind   = out_kind_reg;
    assign result.luhn_ok     = out_ok_reg;
    assign result.digit_count = out_cnt_reg;

endmodule

// ----- hdl/lcc_checker.sv -----
module lcc_checker
    import lcc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [KIND_W-1:0] res_kind,
    input logic              res_ok,
    input logic [CNT_W-1:0]  res_cnt
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_kind) && $stable(res_ok) && $stable(res_cnt))
        else $error("result payload changed while stalled");

    a_kind_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_INVALID |-> res_ok)
        else $error("issuer kind given for a number that fails the check");

    a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            (res_kind != KIND_PREFIX3X || res_cnt == CNT_W'(15)) &&
            (res_kind != KIND_PREFIX5X || res_cnt == CNT_W'(16)) &&
            (res_kind != KIND_PREFIX4 || res_cnt == CNT_W'(16) || res_cnt == CNT_W'(13)))
        else $error("issuer kind does not match digit count");

endmodule

bind luhn_card_number_classifier lcc_checker u_lcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_kind  (result.card_kind),
    .res_ok    (result.luhn_ok),
    .res_cnt   (result.digit_count)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lcc_pkg::*;

    localparam longint unsigned CARD_MAX  = (64'd1 << IN_W) - 64'd1;
    localparam int              LONG_HOLD = 300;
    localparam int              HOLD_AT   = 400;
    localparam int              WATCHDOG  = 3000;

    typedef struct packed {
        logic [KIND_W-1:0] card_kind;
        logic              luhn_ok;
        logic [CNT_W-1:0]  digit_count;
    } verdict_t;

    typedef struct {
        logic [IN_W-1:0] num;
        verdict_t        v;
    } due_t;

    typedef struct {
        logic [IN_W-1:0] num;
        int unsigned     gap;
        bit              drain;
    } card_item_t;

    logic clk;
    logic rst_n;

    lcc_in_if  card_if ();
    lcc_out_if res_if ();

    luhn_card_number_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .card   (card_if),
        .result (res_if)
    );

    card_item_t  cards_to_send[$];
    due_t        verdicts_due[$];
    int          cards_sent     = 0;
    int          cards_taken    = 0;
    int          verdicts_seen  = 0;
    int          rx_seen        = 0;
    int unsigned gap_cnt        = 0;
    int unsigned hold_left      = 0;
    int          err_cnt        = 0;
    int          idle_cycles    = 0;
    int          luhn_pass      = 0;
    int          kind_seen[4]   = '{0, 0, 0, 0};

    // Luhn digit sum over every digit; n returns the significant digit count
    function automatic int unsigned luhn_digit_sum(input longint unsigned v,
                                                   output int unsigned n);
        int unsigned s;
        int unsigned d;
        s = 0;
        n = 0;
        while (v != 0) begin
            d = 32'(v % 64'd10);
            if (n[0]) begin
                d = 2 * d;
                if (d > 9)
                    d = d - 9;
            end
            s = s + d;
            n = n + 1;
            v = v / 64'd10;
        end
        return s;
    endfunction

    function automatic verdict_t classify_card(input logic [IN_W-1:0] num);
        verdict_t        r;
        longint unsigned v;
        longint unsigned lead;
        int unsigned     n;
        int unsigned     s;
        v = 64'(num);
        s = luhn_digit_sum(v, n);
        r.luhn_ok     = (s % 10 == 0);
        r.digit_count = CNT_W'(n);
        r.card_kind   = KIND_INVALID;
        if (r.luhn_ok && n <= MAX_DIGITS) begin
            if (n == 16) begin
                lead = v / 64'd100000000000000;
                if (lead >= 51 && lead <= 55)
                    r.card_kind = KIND_PREFIX5X;
                else if (lead >= 40 && lead <= 49)
                    r.card_kind = KIND_PREFIX4;
            end else if (n == 15) begin
                lead = v / 64'd10000000000000;
                if (lead == 34 || lead == 37)
                    r.card_kind = KIND_PREFIX3X;
            end else if (n == 13) begin
                lead = v / 64'd1000000000000;
                if (lead == 4)
                    r.card_kind = KIND_PREFIX4;
            end
        end
        return r;
    endfunction

    // random body after the lead digits, check digit appended; len counts all digits
    function automatic logic [IN_W-1:0] luhn_number(input int unsigned lead,
                                                    input int unsigned lead_digits,
                                                    input int unsigned len);
        longint unsigned v;
        int unsigned     s;
        int unsigned     n;
        v = CARD_MAX + 64'd1;
        while (v > CARD_MAX) begin
            v = lead;
            for (int unsigned i = lead_digits; i + 1 < len; i++)
                v = v * 64'd10 + $urandom_range(9, 0);
            v = v * 64'd10;
            s = luhn_digit_sum(v, n);
            v = v + (10 - s % 10) % 10;
        end
        return IN_W'(v);
    endfunction

    // nudge the check digit so the sum misses a multiple of ten
    function automatic logic [IN_W-1:0] luhn_break(input logic [IN_W-1:0] num);
        if (64'(num) % 64'd10 == 64'd9)
            return num - 1'b1;
        return num + 1'b1;
    endfunction

    function automatic logic [IN_W-1:0] issuer_number(input int unsigned cls);
        case (cls)
            0:       return luhn_number($urandom_range(55, 51), 2, 16);
            1:       return luhn_number($urandom_range(49, 40), 2, 16);
            2:       return luhn_number($urandom_range(1, 0) ? 37 : 34, 2, 15);
            default: return luhn_number(4, 1, 13);
        endcase
    endfunction

    task automatic add_card(input logic [IN_W-1:0] num, input bit drain);
        card_item_t it;
        it.num   = num;
        it.drain = drain;
        // every fourth block of 128 items goes back to back
        it.gap   = ((cards_to_send.size() / 128) % 4 == 2) ? 0 : $urandom_range(11, 0);
        cards_to_send.push_back(it);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender: presents the next card once the previous one was taken
    always @(negedge clk) begin
        if (rst_n && cards_sent == cards_taken) begin
            if (cards_to_send.size() == 0) begin
                card_if.valid <= 1'b0;
            end else if (cards_to_send[0].drain && verdicts_due.size() != 0) begin
                card_if.valid <= 1'b0;
            end else if (gap_cnt < cards_to_send[0].gap) begin
                card_if.valid <= 1'b0;
                gap_cnt       <= gap_cnt + 1;
            end else begin
                card_if.valid       <= 1'b1;
                card_if.card_number <= cards_to_send[0].num;
                void'(cards_to_send.pop_front());
                cards_sent          <= cards_sent + 1;
                gap_cnt             <= 0;
            end
        end
    end

    // receiver: draws a hold after each verdict, one long hold to back up the pipe
    always @(negedge clk) begin : rx_pace
        int unsigned nh;
        if (rst_n) begin
            if (verdicts_seen != rx_seen) begin
                rx_seen <= verdicts_seen;
                if (verdicts_seen == HOLD_AT)
                    nh = LONG_HOLD;
                else if ((verdicts_seen / 150) % 4 == 3)
                    nh = 0;
                else
                    nh = $urandom_range(11, 0);
                if (nh != 0) begin
                    res_if.ready <= 1'b0;
                    hold_left    <= nh - 1;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end else if (hold_left != 0) begin
                res_if.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_verdicts
        verdict_t got;
        due_t     want;
        if (rst_n) begin
            // pop before push so a verdict never matches a card taken on the same edge
            if (res_if.valid && res_if.ready) begin
                got.card_kind   = res_if.card_kind;
                got.luhn_ok     = res_if.luhn_ok;
                got.digit_count = res_if.digit_count;
                if (verdicts_due.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t unexpected verdict: expected none, %s %0d ok %0d digits %0d",
                             $time, "got kind", got.card_kind, got.luhn_ok,
                             got.digit_count);
                end else begin
                    want = verdicts_due.pop_front();
                    kind_seen[want.v.card_kind] = kind_seen[want.v.card_kind] + 1;
                    if (want.v.luhn_ok)
                        luhn_pass = luhn_pass + 1;
                    if (got.card_kind !== want.v.card_kind || got.luhn_ok !== want.v.luhn_ok ||
                        got.digit_count !== want.v.digit_count) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t card %0d: expected kind %0d ok %0d digits %0d, %s",
                                 $time, want.num, want.v.card_kind, want.v.luhn_ok,
                                 want.v.digit_count, "got:");
                        $display("    kind %0d ok %0d digits %0d",
                                 got.card_kind, got.luhn_ok, got.digit_count);
                    end
                end
                verdicts_seen <= verdicts_seen + 1;
            end
            if (card_if.valid && card_if.ready) begin
                want.num = card_if.card_number;
                want.v   = classify_card(card_if.card_number);
                verdicts_due.push_back(want);
                cards_taken <= cards_taken + 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (card_if.valid && card_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int unsigned     r;
        int unsigned     cls;
        int unsigned     len;
        logic [63:0]     raw;
        rst_n               = 1'b0;
        card_if.valid       = 1'b0;
        card_if.card_number = '0;
        res_if.ready        = 1'b0;

        // directed: extremes, every issuer, near misses, odd lengths
        add_card('0, 1'b0);
        add_card(IN_W'(CARD_MAX), 1'b0);
        add_card(IN_W'(64'd9999999999999999), 1'b0);
        add_card(luhn_number(51, 2, 16), 1'b0);
        add_card(luhn_number(55, 2, 16), 1'b0);
        add_card(luhn_number(40, 2, 16), 1'b0);
        add_card(luhn_number(49, 2, 16), 1'b0);
        add_card(luhn_number(50, 2, 16), 1'b0);
        add_card(luhn_number(56, 2, 16), 1'b0);
        add_card(luhn_number(39, 2, 16), 1'b0);
        add_card(luhn_number(34, 2, 15), 1'b0);
        add_card(luhn_number(37, 2, 15), 1'b0);
        add_card(luhn_number(35, 2, 15), 1'b0);
        add_card(luhn_number(4, 1, 13), 1'b0);
        add_card(luhn_number(5, 1, 13), 1'b0);
        add_card(luhn_number(4, 1, 15), 1'b0);
        add_card(luhn_number(4, 1, 14), 1'b0);
        add_card(luhn_number(1, 1, 17), 1'b0);
        add_card(luhn_number(4, 1, 12), 1'b0);
        add_card(luhn_break(luhn_number(51, 2, 16)), 1'b0);
        add_card(luhn_break(luhn_number(34, 2, 15)), 1'b0);
        add_card(luhn_break(luhn_number(4, 1, 13)), 1'b0);
        add_card(IN_W'(7), 1'b0);

        for (int i = 0; i < 2000; i++) begin
            r   = $urandom_range(99, 0);
            cls = $urandom_range(3, 0);
            if (r < 55) begin
                add_card(issuer_number(cls), i == 0 || i == 1000);
            end else if (r < 65) begin
                if ($urandom_range(1, 0))
                    add_card(luhn_break(issuer_number(cls)), 1'b0);
                else if (cls == 3)
                    add_card(luhn_number($urandom_range(9, 1), 1, 13), 1'b0);
                else
                    add_card(luhn_number($urandom_range(99, 10), 2, cls == 2 ? 15 : 16), 1'b0);
            end else if (r < 80) begin
                len = $urandom_range(17, 2);
                add_card(luhn_number(len == 17 ? 1 : $urandom_range(9, 1), 1, len), 1'b0);
            end else if (r < 90) begin
                raw = {$urandom, $urandom};
                add_card(raw[IN_W-1:0], 1'b0);
            end else begin
                raw = {$urandom, $urandom};
                add_card(raw[IN_W-1:0] >> $urandom_range(IN_W - 1, 0), 1'b0);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cards_to_send.size() != 0 || cards_sent != cards_taken ||
               verdicts_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("%0d cards taken, %0d verdicts checked, %0d with a good Luhn sum",
                 cards_taken, verdicts_seen, luhn_pass);
        $display("kinds: invalid %0d, 34/37 %0d, 51-55 %0d, lead 4 %0d; %0d mismatches",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], err_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
